// ===== design/iee_pkg.sv =====
// ----------------------------------------------------------------------------
// iee_pkg: shared types and constants of the infix expression evaluator
// Payload structs, operator codes, state encodings and character constants.
// ----------------------------------------------------------------------------
package iee_pkg;

    // Fixed field widths of the item payloads.
    localparam int CHAR_W  = 8;
    localparam int VALUE_W = 32;

    // ASCII codes that the decoder recognizes.
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    // Operator codes; bit 1 is the precedence level.
    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_code_t;

    // Input item: one character of the expression.
    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last_char;
    } in_item_t;

    // Result item: value of the whole expression.
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      div_by_zero;
    } out_item_t;

    // Request from the sequencer to the arithmetic unit.
    typedef struct packed {
        logic     start;
        op_code_t op;
    } alu_ctrl_t;

    // Status from the arithmetic unit back to the sequencer.
    typedef struct packed {
        logic done;
        logic div_zero;
    } alu_stat_t;

    // Arithmetic unit states.
    typedef enum logic [1:0] {
        ALU_IDLE,
        ALU_MUL,
        ALU_DIV,
        ALU_FIX
    } alu_state_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        EV_IDLE,
        EV_FLUSH,
        EV_CHECK,
        EV_WAIT,
        EV_OUT
    } eval_state_t;

endpackage

// ===== design/iee_alu.sv =====
// ----------------------------------------------------------------------------
// iee_alu: shared arithmetic unit
// Add and subtract go straight into the result register; multiply by shift and
// add and divide by restoring division, one bit per cycle.
// ----------------------------------------------------------------------------
module iee_alu
    import iee_pkg::*;
#(
    parameter int WIDTH = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  alu_ctrl_t        ctrl,
    input  logic [WIDTH-1:0] lhs,
    input  logic [WIDTH-1:0] rhs,
    output alu_stat_t        stat,
    output logic [WIDTH-1:0] result
);

    localparam int CNT_W = $clog2(WIDTH);

    alu_state_t       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [WIDTH-1:0] a_reg, a_next;
    logic [WIDTH-1:0] b_reg, b_next;
    logic [WIDTH:0]   p_reg, p_next;
    logic             neg_reg, neg_next;
    logic             done_reg, done_next;
    logic             dz_reg, dz_next;
    logic [WIDTH-1:0] res_reg, res_next;

    logic [WIDTH:0]   shifted;
    logic [WIDTH:0]   divisor_ext;
    logic [WIDTH-1:0] mul_sum;

    // State and control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ALU_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        p_reg   <= p_next;
        neg_reg <= neg_next;
        dz_reg  <= dz_next;
        res_reg <= res_next;
    end

    // One step of the shared datapath.
    assign shifted     = {p_reg[WIDTH-1:0], a_reg[WIDTH-1]};
    assign divisor_ext = {1'b0, b_reg};
    assign mul_sum     = p_reg[WIDTH-1:0] + (b_reg[0] ? a_reg : '0);

    // Next state and datapath control.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        p_next     = p_reg;
        neg_next   = neg_reg;
        done_next  = 1'b0;
        dz_next    = 1'b0;
        res_next   = res_reg;

        unique case (state_reg)
            ALU_IDLE:
            begin
                if (ctrl.start)
                begin
                    unique case (ctrl.op)
                        OP_ADD:
                        begin
                            res_next  = lhs + rhs;
                            done_next = 1'b1;
                        end
                        OP_SUB:
                        begin
                            res_next  = lhs - rhs;
                            done_next = 1'b1;
                        end
                        OP_MUL:
                        begin
                            a_next     = lhs;
                            b_next     = rhs;
                            p_next     = '0;
                            cnt_next   = CNT_W'(WIDTH - 1);
                            state_next = ALU_MUL;
                        end
                        OP_DIV:
                        begin
                            if (rhs == '0)
                            begin
                                // A zero divisor gives zero and raises the flag.
                                res_next  = '0;
                                dz_next   = 1'b1;
                                done_next = 1'b1;
                            end
                            else
                            begin
                                a_next     = lhs[WIDTH-1] ? -lhs : lhs;
                                b_next     = rhs[WIDTH-1] ? -rhs : rhs;
                                neg_next   = lhs[WIDTH-1] ^ rhs[WIDTH-1];
                                p_next     = '0;
                                cnt_next   = CNT_W'(WIDTH - 1);
                                state_next = ALU_DIV;
                            end
                        end
                        default:
                        begin
                            res_next = res_reg;
                        end
                    endcase
                end
            end
            ALU_MUL:
            begin
                p_next = {1'b0, mul_sum};
                a_next = {a_reg[WIDTH-2:0], 1'b0};
                b_next = {1'b0, b_reg[WIDTH-1:1]};
                if (cnt_reg == '0)
                begin
                    res_next   = mul_sum;
                    done_next  = 1'b1;
                    state_next = ALU_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ALU_DIV:
            begin
                // The dividend register fills with quotient bits from the right.
                if (shifted >= divisor_ext)
                begin
                    p_next = shifted - divisor_ext;
                    a_next = {a_reg[WIDTH-2:0], 1'b1};
                end
                else
                begin
                    p_next = shifted;
                    a_next = {a_reg[WIDTH-2:0], 1'b0};
                end
                if (cnt_reg == '0)
                begin
                    state_next = ALU_FIX;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ALU_FIX:
            begin
                res_next   = neg_reg ? -a_reg : a_reg;
                done_next  = 1'b1;
                state_next = ALU_IDLE;
            end
            default:
            begin
                state_next = ALU_IDLE;
            end
        endcase
    end

    assign stat.done     = done_reg;
    assign stat.div_zero = dz_reg;
    assign result        = res_reg;

endmodule

// ===== design/infix_expression_evaluator_top.sv =====
// ----------------------------------------------------------------------------
// infix_expression_evaluator_top: streaming two-level infix evaluator
// Builds numbers from digits, keeps a three-deep number stack and a two-deep
// operator stack, and reduces through one shared arithmetic unit.
// ----------------------------------------------------------------------------
// A digit is folded into the accumulator in the idle state; a space or operator
// passes through the flush and check states, and each reduction waits in the
// wait state for the shared unit, whose multiply and divide are bit-serial.
// The last character reduces all stacked operators (up to two) before the
// result item is offered; the block takes no item until it is taken.
// Reset (rst_n, asynchronous, active low) empties both stacks and clears the
// number accumulator and the division-by-zero flag.
module infix_expression_evaluator_top
    import iee_pkg::*;
#(
    parameter int WIDTH = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    eval_state_t      state_reg, state_next;
    logic [WIDTH-1:0] num_reg [3];
    logic [WIDTH-1:0] num_next [3];
    logic [1:0]       nc_reg, nc_next;
    op_code_t         ops_reg [2];
    op_code_t         ops_next [2];
    logic [1:0]       oc_reg, oc_next;
    logic [WIDTH-1:0] acc_reg, acc_next;
    logic             in_num_reg, in_num_next;
    logic             err_reg, err_next;
    op_code_t         code_reg, code_next;
    logic             pend_reg, pend_next;
    logic             last_reg, last_next;
    out_item_t        out_reg, out_next;

    alu_ctrl_t        alu_ctrl;
    alu_stat_t        alu_stat;
    logic [WIDTH-1:0] alu_lhs;
    logic [WIDTH-1:0] alu_rhs;
    logic [WIDTH-1:0] alu_result;

    logic             is_digit;
    logic             is_op;
    op_code_t         in_code;
    op_code_t         top_op;
    logic [WIDTH-1:0] top_num;
    logic [WIDTH-1:0] push_val;
    logic [1:0]       push_cnt;
    logic             push_en;

    // Shared arithmetic unit.
    iee_alu #(
        .WIDTH (WIDTH)
    ) u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (alu_ctrl),
        .lhs    (alu_lhs),
        .rhs    (alu_rhs),
        .stat   (alu_stat),
        .result (alu_result)
    );

    // Character decode.
    assign is_digit = (in_item.char_code >= CH_ZERO) && (in_item.char_code <= CH_NINE);

    always_comb
    begin
        is_op   = 1'b1;
        in_code = OP_ADD;
        priority if (in_item.char_code == CH_PLUS)
        begin
            in_code = OP_ADD;
        end
        else if (in_item.char_code == CH_MINUS)
        begin
            in_code = OP_SUB;
        end
        else if (in_item.char_code == CH_STAR)
        begin
            in_code = OP_MUL;
        end
        else if (in_item.char_code == CH_SLASH)
        begin
            in_code = OP_DIV;
        end
        else
        begin
            is_op = 1'b0;
        end
    end

    // Top entries of both stacks.
    always_comb
    begin
        unique case (oc_reg)
            2'd2:    top_op = ops_reg[1];
            default: top_op = ops_reg[0];
        endcase
        unique case (nc_reg)
            2'd0:    top_num = '0;
            2'd1:    top_num = num_reg[0];
            2'd2:    top_num = num_reg[1];
            default: top_num = num_reg[2];
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= EV_IDLE;
            nc_reg     <= '0;
            oc_reg     <= '0;
            acc_reg    <= '0;
            in_num_reg <= 1'b0;
            err_reg    <= 1'b0;
            pend_reg   <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            nc_reg     <= nc_next;
            oc_reg     <= oc_next;
            acc_reg    <= acc_next;
            in_num_reg <= in_num_next;
            err_reg    <= err_next;
            pend_reg   <= pend_next;
            last_reg   <= last_next;
        end
    end

    // Stack contents and payload registers.
    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        ops_reg  <= ops_next;
        code_reg <= code_next;
        out_reg  <= out_next;
    end

    // Sequencer: next state, stack updates and arithmetic requests.
    always_comb
    begin
        state_next  = state_reg;
        num_next    = num_reg;
        nc_next     = nc_reg;
        ops_next    = ops_reg;
        oc_next     = oc_reg;
        acc_next    = acc_reg;
        in_num_next = in_num_reg;
        err_next    = err_reg;
        code_next   = code_reg;
        pend_next   = pend_reg;
        last_next   = last_reg;
        out_next    = out_reg;
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        alu_ctrl    = '0;
        alu_lhs     = '0;
        alu_rhs     = '0;
        push_en     = 1'b0;
        push_val    = acc_reg;
        push_cnt    = nc_reg;

        unique case (state_reg)
            EV_IDLE:
            begin
                // The block is always ready here, so valid alone accepts an item.
                in_ready = 1'b1;
                if (in_valid)
                begin
                    last_next = in_item.last_char;
                    if (is_digit)
                    begin
                        // acc * 10 + digit, wrapping at WIDTH bits.
                        acc_next    = (acc_reg << 3) + (acc_reg << 1)
                                    + WIDTH'(in_item.char_code[3:0]);
                        in_num_next = 1'b1;
                        pend_next   = 1'b0;
                        if (in_item.last_char)
                        begin
                            state_next = EV_FLUSH;
                        end
                    end
                    else
                    begin
                        pend_next  = is_op;
                        code_next  = in_code;
                        state_next = EV_FLUSH;
                    end
                end
            end
            EV_FLUSH:
            begin
                // A number in progress is ended and pushed.
                if (in_num_reg)
                begin
                    push_en     = 1'b1;
                    push_val    = acc_reg;
                    push_cnt    = nc_reg;
                    acc_next    = '0;
                    in_num_next = 1'b0;
                end
                state_next = EV_CHECK;
            end
            EV_CHECK:
            begin
                if ((oc_reg != '0) && (pend_reg ? (code_reg[1] <= top_op[1]) : last_reg))
                begin
                    // Pop one operator and two operands; missing operands read as zero.
                    alu_ctrl.start = 1'b1;
                    alu_ctrl.op    = top_op;
                    oc_next        = oc_reg - 1'b1;
                    unique case (nc_reg)
                        2'd0:
                        begin
                            alu_lhs = '0;
                            alu_rhs = '0;
                            nc_next = 2'd0;
                        end
                        2'd1:
                        begin
                            alu_lhs = '0;
                            alu_rhs = num_reg[0];
                            nc_next = 2'd0;
                        end
                        2'd2:
                        begin
                            alu_lhs = num_reg[0];
                            alu_rhs = num_reg[1];
                            nc_next = 2'd0;
                        end
                        default:
                        begin
                            alu_lhs = num_reg[1];
                            alu_rhs = num_reg[2];
                            nc_next = 2'd1;
                        end
                    endcase
                    state_next = EV_WAIT;
                end
                else if (pend_reg)
                begin
                    // Push the new operator; a full stack overwrites its top.
                    unique case (oc_reg)
                        2'd0:
                        begin
                            ops_next[0] = code_reg;
                            oc_next     = 2'd1;
                        end
                        2'd1:
                        begin
                            ops_next[1] = code_reg;
                            oc_next     = 2'd2;
                        end
                        default:
                        begin
                            ops_next[1] = code_reg;
                        end
                    endcase
                    pend_next = 1'b0;
                end
                else if (last_reg)
                begin
                    out_next.value       = VALUE_W'(top_num);
                    out_next.div_by_zero = err_reg;
                    state_next           = EV_OUT;
                end
                else
                begin
                    state_next = EV_IDLE;
                end
            end
            EV_WAIT:
            begin
                if (alu_stat.done)
                begin
                    push_en    = 1'b1;
                    push_val   = alu_result;
                    push_cnt   = nc_reg;
                    err_next   = err_reg | alu_stat.div_zero;
                    state_next = EV_CHECK;
                end
            end
            EV_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    // Back to the empty state for the next expression.
                    nc_next     = '0;
                    oc_next     = '0;
                    acc_next    = '0;
                    in_num_next = 1'b0;
                    err_next    = 1'b0;
                    pend_next   = 1'b0;
                    last_next   = 1'b0;
                    state_next  = EV_IDLE;
                end
            end
            default:
            begin
                state_next = EV_IDLE;
            end
        endcase

        // Number push; a full stack overwrites its top entry.
        if (push_en)
        begin
            unique case (push_cnt)
                2'd0:
                begin
                    num_next[0] = push_val;
                    nc_next     = 2'd1;
                end
                2'd1:
                begin
                    num_next[1] = push_val;
                    nc_next     = 2'd2;
                end
                2'd2:
                begin
                    num_next[2] = push_val;
                    nc_next     = 2'd3;
                end
                default:
                begin
                    num_next[2] = push_val;
                    nc_next     = 2'd3;
                end
            endcase
        end
    end

    assign out_item = out_reg;

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for the infix expression evaluator
// Streams expressions one character per item into the evaluator. A predictor
// in the testbench tracks the number and operator stacks and queues the value
// expected for each finished expression. Each result item is compared with
// the oldest queued value. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
    import iee_pkg::*;

    localparam int W              = VALUE_W;
    localparam int NUM_DEPTH      = 3;
    localparam int OP_DEPTH       = 2;
    localparam int CHAR_TARGET    = 1450;
    localparam int DRAIN_SPACING  = 300;
    localparam int LONG_HOLD      = 600;
    localparam int HOLD_AFTER     = 12;
    localparam int IDLE_LIMIT     = 4000;
    localparam int SETTLE_CYCLES  = 200;
    localparam logic [W-1:0] DEC_RADIX = 10;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    // Operator characters indexed by operator code.
    localparam logic [CHAR_W-1:0] OP_CHARS [4] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_item_t  in_item   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_item;

    // Characters waiting to be offered, with a flag that holds the sender
    // until every predicted value has been received.
    in_item_t  char_q [$];
    bit        drain_q [$];

    // Predicted values of finished expressions, oldest first.
    out_item_t predicted_results [$];

    int        err_count    = 0;
    int        results_seen = 0;
    int        idle_cycles  = 0;
    logic      in_taken     = 1'b0;
    out_item_t want;

    // Evaluator state mirrored by the predictor.
    logic [W-1:0] num_stack [NUM_DEPTH];
    int           num_depth;
    op_code_t     op_stack [OP_DEPTH];
    int           op_depth;
    logic [W-1:0] digit_acc;
    bit           mid_number;
    bit           zero_div_seen;

    infix_expression_evaluator_top #(.WIDTH(W)) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic void clear_eval();
        for (int i = 0; i < NUM_DEPTH; i++)
        begin
            num_stack[i] = '0;
        end
        for (int i = 0; i < OP_DEPTH; i++)
        begin
            op_stack[i] = OP_ADD;
        end
        num_depth     = 0;
        op_depth      = 0;
        digit_acc     = '0;
        mid_number    = 1'b0;
        zero_div_seen = 1'b0;
    endfunction

    // A push onto a full number stack replaces the top entry.
    function automatic void push_operand(input logic [W-1:0] v);
        if (num_depth < NUM_DEPTH)
        begin
            num_stack[num_depth] = v;
            num_depth++;
        end
        else
        begin
            num_stack[NUM_DEPTH-1] = v;
        end
    endfunction

    function automatic void push_operator(input op_code_t code);
        if (op_depth < OP_DEPTH)
        begin
            op_stack[op_depth] = code;
            op_depth++;
        end
        else
        begin
            op_stack[OP_DEPTH-1] = code;
        end
    endfunction

    // Signed division truncating toward zero; a zero divisor gives zero.
    function automatic logic [W-1:0] quotient(input logic [W-1:0] l, input logic [W-1:0] r);
        logic [W-1:0] mag_l;
        logic [W-1:0] mag_r;
        logic [W-1:0] q;
        if (r == '0)
        begin
            zero_div_seen = 1'b1;
            return '0;
        end
        mag_l = l[W-1] ? -l : l;
        mag_r = r[W-1] ? -r : r;
        q = mag_l / mag_r;
        if (l[W-1] != r[W-1])
        begin
            q = -q;
        end
        return q;
    endfunction

    // Apply the top operator; a missing operand counts as zero.
    function automatic void reduce_top();
        logic [W-1:0] l;
        logic [W-1:0] r;
        logic [W-1:0] res;
        op_code_t     code;
        l = '0;
        r = '0;
        if (op_depth == 0)
        begin
            return;
        end
        op_depth--;
        code = op_stack[op_depth];
        if (num_depth > 0)
        begin
            num_depth--;
            r = num_stack[num_depth];
        end
        if (num_depth > 0)
        begin
            num_depth--;
            l = num_stack[num_depth];
        end
        case (code)
            OP_ADD:  res = l + r;
            OP_SUB:  res = l - r;
            OP_MUL:  res = l * r;
            default: res = quotient(l, r);
        endcase
        push_operand(res);
    endfunction

    // Advance the prediction by one accepted character.
    function automatic void eval_char(input in_item_t it);
        logic [CHAR_W-1:0] c;
        op_code_t          code;
        bit                is_op;
        out_item_t         res;
        c = it.char_code;
        code = OP_ADD;
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            digit_acc  = digit_acc * DEC_RADIX + W'(c - CH_ZERO);
            mid_number = 1'b1;
        end
        else
        begin
            // Anything that is not a digit ends the current number.
            if (mid_number)
            begin
                push_operand(digit_acc);
                digit_acc  = '0;
                mid_number = 1'b0;
            end
            is_op = 1'b1;
            case (c)
                CH_PLUS:  code = OP_ADD;
                CH_MINUS: code = OP_SUB;
                CH_STAR:  code = OP_MUL;
                CH_SLASH: code = OP_DIV;
                default:  is_op = 1'b0;
            endcase
            if (is_op)
            begin
                while (op_depth > 0 && code[1] <= op_stack[op_depth-1][1])
                begin
                    reduce_top();
                end
                push_operator(code);
            end
        end

        // The last character closes the expression and yields its value.
        if (it.last_char)
        begin
            if (mid_number)
            begin
                push_operand(digit_acc);
            end
            while (op_depth > 0)
            begin
                reduce_top();
            end
            res.value       = (num_depth > 0) ? num_stack[num_depth-1] : '0;
            res.div_by_zero = zero_div_seen;
            predicted_results.push_back(res);
            clear_eval();
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------

    // Queue one expression; the final character carries the last flag.
    task automatic queue_expr(input logic [CHAR_W-1:0] text [$], input bit drain);
        in_item_t it;
        for (int i = 0; i < text.size(); i++)
        begin
            it.char_code = text[i];
            it.last_char = (i == text.size() - 1);
            char_q.push_back(it);
            drain_q.push_back(drain && (i == 0));
        end
    endtask

    task automatic queue_text(input string s, input bit drain);
        logic [CHAR_W-1:0] text [$];
        for (int i = 0; i < s.len(); i++)
        begin
            text.push_back(s[i]);
        end
        queue_expr(text, drain);
    endtask

    // Append a decimal number: mostly short, sometimes long enough to wrap.
    task automatic add_number(inout logic [CHAR_W-1:0] text [$]);
        int unsigned pick;
        int unsigned ndig;
        pick = $urandom_range(0, 15);
        if (pick == 0)
        begin
            text.push_back(CH_ZERO);
        end
        else if (pick == 1)
        begin
            // Either the most negative value or minus one after wrapping.
            if ($urandom_range(0, 1) == 0)
                queue_digits(text, "2147483648");
            else
                queue_digits(text, "4294967295");
        end
        else
        begin
            ndig = (pick < 4) ? $urandom_range(4, 11) : $urandom_range(1, 3);
            repeat (ndig)
            begin
                text.push_back(CH_ZERO + CHAR_W'($urandom_range(0, 9)));
            end
        end
    endtask

    task automatic queue_digits(inout logic [CHAR_W-1:0] text [$], input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            text.push_back(s[i]);
        end
    endtask

    task automatic maybe_space(inout logic [CHAR_W-1:0] text [$]);
        if ($urandom_range(0, 3) == 0)
        begin
            text.push_back(CH_SPACE);
        end
    endtask

    // Build one random expression. Most are well formed; some carry a leading or
    // trailing operator, stray characters or a dropped number, or are pure noise.
    task automatic gen_expr(output logic [CHAR_W-1:0] text [$]);
        int unsigned kind;
        int unsigned nops;
        text = {};
        kind = $urandom_range(0, 11);
        if (kind == 0)
        begin
            repeat ($urandom_range(1, 6))
            begin
                text.push_back(CHAR_W'($urandom_range(0, 255)));
            end
        end
        else
        begin
            nops = $urandom_range(0, 4);
            maybe_space(text);
            if (kind == 1)
            begin
                text.push_back(OP_CHARS[$urandom_range(0, 3)]);
            end
            add_number(text);
            for (int k = 0; k < nops; k++)
            begin
                maybe_space(text);
                text.push_back(OP_CHARS[$urandom_range(0, 3)]);
                maybe_space(text);
                if (kind == 2 && $urandom_range(0, 2) == 0)
                begin
                    text.push_back(CHAR_W'($urandom_range(0, 255)));
                end
                if (!(kind == 3 && $urandom_range(0, 2) == 0))
                begin
                    add_number(text);
                end
            end
            if (kind == 4)
            begin
                text.push_back(OP_CHARS[$urandom_range(0, 3)]);
            end
            maybe_space(text);
        end
    endtask

    // Fill the character queue, then wait for the run to drain.
    initial
    begin
        logic [CHAR_W-1:0] text [$];
        int                since_drain;
        clear_eval();

        // Directed expressions: empty input, most negative divided by
        // minus one, every operator and a zero divisor, an overfull
        // number stack, and a stray character before a trailing operator.
        queue_text(" ", 1'b0);
        queue_text("2147483648/4294967295", 1'b0);
        queue_text("9-8*7+6/0", 1'b0);
        queue_text("1 2 3 4", 1'b0);
        queue_text("5#-", 1'b0);

        since_drain = DRAIN_SPACING;
        while (char_q.size() < CHAR_TARGET)
        begin
            gen_expr(text);
            if (since_drain >= DRAIN_SPACING)
            begin
                queue_expr(text, 1'b1);
                since_drain = 0;
            end
            else
            begin
                queue_expr(text, 1'b0);
            end
            since_drain += text.size();
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (char_q.size() != 0 || in_valid)
        begin
            @(negedge clk);
        end
        while (predicted_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (predicted_results.size() != 0)
        begin
            $error("%0d predicted results never arrived", predicted_results.size());
            err_count++;
        end
        if (err_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Character driver: bursts of items separated by random gaps
    // ------------------------------------------------------------------
    int unsigned burst_left = 1;
    int unsigned gap_left   = 0;

    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (char_q.size() != 0 &&
                     !(drain_q[0] && predicted_results.size() != 0))
            begin
                in_item <= char_q.pop_front();
                void'(drain_q.pop_front());
                in_valid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                end
                else
                begin
                    burst_left--;
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: changing stall pattern plus one long hold-off
    // ------------------------------------------------------------------
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    int unsigned mode      = 0;
    int unsigned mode_left = 0;

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (!hold_done && results_seen >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
                out_ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 2);
                    mode_left = $urandom_range(16, 96);
                end
                else
                begin
                    mode_left--;
                end
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= ($urandom_range(0, 1) == 0);
                    default: out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on accepted characters, check accepted results
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_taken <= in_valid && in_ready;
            if (in_valid && in_ready)
            begin
                eval_char(in_item);
            end
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (predicted_results.size() == 0)
                begin
                    $error("unexpected result item: value %0d div_by_zero %0b",
                           $signed(out_item.value), out_item.div_by_zero);
                    err_count++;
                end
                else
                begin
                    want = predicted_results.pop_front();
                    if (out_item.value !== want.value)
                    begin
                        $error("value: expected %0d, actual %0d",
                               $signed(want.value), $signed(out_item.value));
                        err_count++;
                    end
                    if (out_item.div_by_zero !== want.div_by_zero)
                    begin
                        $error("div_by_zero: expected %0b, actual %0b",
                               want.div_by_zero, out_item.div_by_zero);
                        err_count++;
                    end
                end
            end
        end
    end

    // Watchdog: end the run if no item moves on either side for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

endmodule
